FILE: hw/rtl/tcmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcmd_pkg;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    FUNC_BYTE  = 2'd0,
    FUNC_POLL  = 2'd1,
    FUNC_OPEN  = 2'd2,
    FUNC_CLOSE = 2'd3
  } func_t;

  // result actions
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_GREET   = 3'd1,
    ACT_PROMPT  = 3'd2,
    ACT_HELP    = 3'd3,
    ACT_TIME    = 3'd4,
    ACT_ERROR   = 3'd5,
    ACT_EXIT    = 3'd6,
    ACT_TIMEOUT = 3'd7
  } action_t;

  // parser outcome carried down the uptime pipeline
  typedef struct packed {
    action_t action;
    logic    green;
    logic    red;
  } res_t;

  localparam logic [15:0] IDLE_RELOAD_RESET = 16'd240;

endpackage

`default_nettype wire

FILE: hw/rtl/tcmd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module tcmd_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wr_en,
  input  wire logic [15:0]     cfg_wr_data,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tcmd_pkg::func_t in_func,
  input  wire logic [7:0]      in_byte,
  input  wire logic [31:0]     in_uptime,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tcmd_pkg::res_t       out_res,
  output logic [31:0]          out_uptime
);

  import tcmd_pkg::*;

  typedef enum logic [3:0] {
    MODE_CLOSED,
    MODE_INIT,
    MODE_IAC,
    MODE_OPTION,
    MODE_HELP,
    MODE_GON,
    MODE_GOFF,
    MODE_RON,
    MODE_ROFF,
    MODE_TIME,
    MODE_EXIT,
    MODE_ERROR
  } mode_t;

  localparam logic [7:0] CH_IAC  = 8'd255;
  localparam logic [7:0] CH_DO   = 8'd253;
  localparam logic [7:0] CH_DONT = 8'd254;
  localparam logic [7:0] CH_WILL = 8'd251;
  localparam logic [7:0] CH_WONT = 8'd252;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SP   = 8'h20;

  // command letter to waiting mode
  function automatic mode_t letter_mode(input logic [7:0] c);
    mode_t m;
    case (c)
      8'h68, 8'h3F: m = MODE_HELP;   // 'h' and '?'
      8'h47:        m = MODE_GON;    // 'G'
      8'h67:        m = MODE_GOFF;   // 'g'
      8'h52:        m = MODE_RON;    // 'R'
      8'h72:        m = MODE_ROFF;   // 'r'
      8'h74:        m = MODE_TIME;   // 't'
      8'h78:        m = MODE_EXIT;   // 'x'
      default:      m = MODE_ERROR;
    endcase
    return m;
  endfunction

  mode_t       mode;
  mode_t       mode_next;
  logic [15:0] countdown;
  logic [15:0] countdown_next;
  logic [15:0] idle_reload;
  logic        green;
  logic        green_next;
  logic        red;
  logic        red_next;
  action_t     act_next;
  logic        is_blank;
  logic        is_lf;
  logic        take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign is_blank = in_byte inside {CH_SP, CH_TAB, CH_CR};
  assign is_lf    = (in_byte == CH_LF);

  // next session state for the item at the input
  always_comb begin
    mode_next      = mode;
    countdown_next = countdown;
    green_next     = green;
    red_next       = red;
    act_next       = ACT_NONE;
    case (in_func)
      FUNC_OPEN: begin
        mode_next      = MODE_INIT;
        countdown_next = idle_reload;
        act_next       = ACT_GREET;
      end
      FUNC_CLOSE: begin
        mode_next = MODE_CLOSED;
      end
      FUNC_POLL: begin
        if (mode != MODE_CLOSED) begin
          if (countdown <= 16'd1) begin
            countdown_next = '0;
            mode_next      = MODE_CLOSED;
            act_next       = ACT_TIMEOUT;
          end else begin
            countdown_next = countdown - 16'd1;
          end
        end
      end
      FUNC_BYTE: begin
        if (mode != MODE_CLOSED) begin
          countdown_next = idle_reload;
          case (mode)
            MODE_INIT: begin
              if (in_byte == CH_IAC) begin
                mode_next = MODE_IAC;
              end else if (is_lf) begin
                act_next = ACT_PROMPT;
              end else if (!is_blank) begin
                mode_next = letter_mode(in_byte);
              end
            end
            MODE_IAC: begin
              if (in_byte inside {CH_WILL, CH_WONT, CH_DO, CH_DONT}) begin
                mode_next = MODE_OPTION;
              end else begin
                mode_next = MODE_ERROR;
              end
            end
            MODE_OPTION: begin
              mode_next = MODE_INIT;
            end
            MODE_ERROR: begin
              if (is_lf) begin
                mode_next = MODE_INIT;
                act_next  = ACT_ERROR;
              end
            end
            MODE_HELP, MODE_GON, MODE_GOFF, MODE_RON, MODE_ROFF, MODE_TIME,
            MODE_EXIT: begin
              // letter seen, waiting for its newline
              if (!is_blank) begin
                if (!is_lf) begin
                  mode_next = MODE_ERROR;
                end else begin
                  mode_next = MODE_INIT;
                  case (mode)
                    MODE_HELP: act_next = ACT_HELP;
                    MODE_GON: begin
                      green_next = 1'b1;
                      act_next   = ACT_PROMPT;
                    end
                    MODE_GOFF: begin
                      green_next = 1'b0;
                      act_next   = ACT_PROMPT;
                    end
                    MODE_RON: begin
                      red_next = 1'b1;
                      act_next = ACT_PROMPT;
                    end
                    MODE_ROFF: begin
                      red_next = 1'b0;
                      act_next = ACT_PROMPT;
                    end
                    MODE_TIME: act_next = ACT_TIME;
                    MODE_EXIT: begin
                      mode_next = MODE_CLOSED;
                      act_next  = ACT_EXIT;
                    end
                    default: act_next = ACT_NONE;
                  endcase
                end
              end
            end
            default: mode_next = mode;
          endcase
        end
      end
      default: mode_next = mode;
    endcase
  end

  // session state, reload register and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_CLOSED;
      countdown   <= '0;
      green       <= 1'b0;
      red         <= 1'b0;
      idle_reload <= IDLE_RELOAD_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        idle_reload <= cfg_wr_data;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (take) begin
        mode           <= mode_next;
        countdown      <= countdown_next;
        green          <= green_next;
        red            <= red_next;
        out_res.action <= act_next;
        out_res.green  <= green_next;
        out_res.red    <= red_next;
        out_uptime     <= in_uptime;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tcmd_uptime_split.sv
`timescale 1ns / 1ps
`default_nettype none

module tcmd_uptime_split (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tcmd_pkg::res_t in_res,
  input  wire logic [31:0]    in_uptime,
  output logic                out_valid,
  input  wire logic           out_stall,
  output tcmd_pkg::res_t      out_res,
  output logic [5:0]          out_days,
  output logic [4:0]          out_hours,
  output logic [5:0]          out_minutes,
  output logic [5:0]          out_seconds,
  output logic [9:0]          out_millis
);

  import tcmd_pkg::*;

  // reciprocal constants, exact for all 32-bit dividends
  localparam logic [28:0] RECIP_1000 = 29'h10624DD3;  // shift 38
  localparam logic [31:0] RECIP_60   = 32'h88888889;  // shift 37
  localparam logic [31:0] RECIP_24   = 32'hAAAAAAAB;  // shift 36
  localparam logic [31:0] DIV_MS     = 32'd1000;
  localparam logic [22:0] DIV_SEC    = 23'd60;
  localparam logic [16:0] DIV_MIN    = 17'd60;
  localparam logic [10:0] DIV_HOUR   = 11'd24;

  logic [4:0] v;
  logic [4:0] rdy;

  // stage 1: t * (1/1000)
  res_t        r1;
  logic [31:0] t1;
  logic [60:0] p1;
  // stage 2: milliseconds, q1 * (1/60)
  res_t        r2;
  logic [22:0] q1_2;
  logic [9:0]  ms2;
  logic [54:0] p2;
  // stage 3: seconds, q2 * (1/60)
  res_t        r3;
  logic [16:0] q2_3;
  logic [9:0]  ms3;
  logic [5:0]  s3;
  logic [48:0] p3;
  // stage 4: minutes, q3 * (1/24)
  res_t        r4;
  logic [10:0] q3_4;
  logic [9:0]  ms4;
  logic [5:0]  s4;
  logic [5:0]  mi4;
  logic [42:0] p4;

  logic [22:0] q1;
  logic [31:0] ms_full;
  logic [16:0] q2;
  logic [22:0] s_full;
  logic [10:0] q3;
  logic [16:0] mi_full;
  logic [5:0]  q4;
  logic [10:0] h_full;
  logic        is_time;

  // stall chain from the output back
  always_comb begin
    rdy[4] = !v[4] || !out_stall;
    rdy[3] = !v[3] || rdy[4];
    rdy[2] = !v[2] || rdy[3];
    rdy[1] = !v[1] || rdy[2];
    rdy[0] = !v[0] || rdy[1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[4];

  // quotients are the high bits of the registered products
  assign q1      = p1[60:38];
  assign ms_full = t1 - 32'(q1) * DIV_MS;
  assign q2      = p2[53:37];
  assign s_full  = q1_2 - 23'(q2) * DIV_SEC;
  assign q3      = p3[47:37];
  assign mi_full = q2_3 - 17'(q3) * DIV_MIN;
  assign q4      = p4[41:36];
  assign h_full  = q3_4 - 11'(q4) * DIV_HOUR;
  assign is_time = (r4.action == ACT_TIME);

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) v[4] <= v[3];
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      r1 <= in_res;
      t1 <= in_uptime;
      p1 <= 61'(in_uptime) * 61'(RECIP_1000);
    end
    if (rdy[1] && v[0]) begin
      r2   <= r1;
      q1_2 <= q1;
      ms2  <= ms_full[9:0];
      p2   <= 55'(q1) * 55'(RECIP_60);
    end
    if (rdy[2] && v[1]) begin
      r3   <= r2;
      q2_3 <= q2;
      ms3  <= ms2;
      s3   <= s_full[5:0];
      p3   <= 49'(q2) * 49'(RECIP_60);
    end
    if (rdy[3] && v[2]) begin
      r4   <= r3;
      q3_4 <= q3;
      ms4  <= ms3;
      s4   <= s3;
      mi4  <= mi_full[5:0];
      p4   <= 43'(q3) * 43'(RECIP_24);
    end
    if (rdy[4] && v[3]) begin
      out_res     <= r4;
      out_days    <= is_time ? q4 : '0;
      out_hours   <= is_time ? h_full[4:0] : '0;
      out_minutes <= is_time ? mi4 : '0;
      out_seconds <= is_time ? s4 : '0;
      out_millis  <= is_time ? ms4 : '0;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/telnet_command_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Single-letter command parser for one telnet-style session.
// Input channel (in_valid/in_stall): one beat per event: a received byte,
// a poll tick, a session open or a peer close, with the uptime in ms.
// Output channel (out_valid/out_stall): exactly one beat per input beat,
// in order, carrying the action, both LED levels and, for a time report,
// the uptime split into days, hours, minutes, seconds and milliseconds.
// idle_reload is written via cfg_wr_en/cfg_wr_data; the user must do so
// only while no beat is in flight; the block does not enforce it. It sets
// how many poll ticks without data close the session.
// Stages: input register, parser stage, five reciprocal division stages.
// Throughput: one beat per cycle while out_stall is low; the session state
// is updated within the parser stage, so back-to-back bytes need no gaps.
// Stall: a stalled output holds its beat; empty stages keep filling, and
// in_stall rises once every stage holds a beat.
// Reset: pipeline empty, session closed, LEDs off, idle countdown zero,
// idle_reload back to 240.
module telnet_command_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  byte_value,
  input  wire logic [31:0] uptime_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       action,
  output logic             green_led,
  output logic             red_led,
  output logic [5:0]       up_days,
  output logic [4:0]       up_hours,
  output logic [5:0]       up_minutes,
  output logic [5:0]       up_seconds,
  output logic [9:0]       up_millis
);

  import tcmd_pkg::*;

  logic        iv;
  func_t       func_q;
  logic [7:0]  byte_q;
  logic [31:0] uptime_q;
  logic        p_ready;
  logic        p_valid;
  res_t        p_res;
  logic [31:0] p_uptime;
  logic        s_ready;
  res_t        o_res;

  assign in_stall = iv && !p_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (!in_stall) begin
      iv <= in_valid;
      if (in_valid) begin
        func_q   <= func_t'(func);
        byte_q   <= byte_value;
        uptime_q <= uptime_ms;
      end
    end
  end

  tcmd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (iv),
    .in_ready    (p_ready),
    .in_func     (func_q),
    .in_byte     (byte_q),
    .in_uptime   (uptime_q),
    .out_valid   (p_valid),
    .out_ready   (s_ready),
    .out_res     (p_res),
    .out_uptime  (p_uptime)
  );

  tcmd_uptime_split u_split (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (p_valid),
    .in_ready    (s_ready),
    .in_res      (p_res),
    .in_uptime   (p_uptime),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (o_res),
    .out_days    (up_days),
    .out_hours   (up_hours),
    .out_minutes (up_minutes),
    .out_seconds (up_seconds),
    .out_millis  (up_millis)
  );

  assign action    = o_res.action;
  assign green_led = o_res.green;
  assign red_led   = o_res.red;

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import tcmd_pkg::*;

  // telnet option and line characters
  localparam logic [7:0] CH_WILL = 8'd251;
  localparam logic [7:0] CH_WONT = 8'd252;
  localparam logic [7:0] CH_DO   = 8'd253;
  localparam logic [7:0] CH_DONT = 8'd254;
  localparam logic [7:0] CH_IAC  = 8'd255;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SP   = 8'h20;

  // command letters
  localparam logic [7:0] CMD_HELP      = "h";
  localparam logic [7:0] CMD_QUERY     = "?";
  localparam logic [7:0] CMD_GREEN_ON  = "G";
  localparam logic [7:0] CMD_GREEN_OFF = "g";
  localparam logic [7:0] CMD_RED_ON    = "R";
  localparam logic [7:0] CMD_RED_OFF   = "r";
  localparam logic [7:0] CMD_TIME      = "t";
  localparam logic [7:0] CMD_EXIT      = "x";
  localparam logic [7:0] CMD_DOLLAR    = "$";

  localparam int BEATS_PER_PHASE = 540;

  typedef enum logic [3:0] {
    PM_CLOSED, PM_INIT, PM_IAC, PM_OPTION, PM_HELP, PM_GREEN_ON, PM_GREEN_OFF,
    PM_RED_ON, PM_RED_OFF, PM_TIME, PM_EXIT, PM_SWALLOW
  } session_mode_t;

  typedef struct packed {
    action_t     action;
    logic        green;
    logic        red;
    logic [5:0]  days;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [9:0]  millis;
  } session_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = FUNC_BYTE;
  logic [7:0]  byte_value = 8'd0;
  logic [31:0] uptime_ms = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  action;
  logic        green_led;
  logic        red_led;
  logic [5:0]  up_days;
  logic [4:0]  up_hours;
  logic [5:0]  up_minutes;
  logic [5:0]  up_seconds;
  logic [9:0]  up_millis;

  // session model state
  session_mode_t session_mode = PM_CLOSED;
  logic [15:0]   idle_count = 16'd0;
  logic [15:0]   idle_reload = IDLE_RELOAD_RESET;
  logic          green_level = 1'b0;
  logic          red_level = 1'b0;

  session_result_t pending_results[$];
  session_result_t result_want;
  int              fail_count = 0;
  int              beats_sent = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              end_wait;

  telnet_command_parser uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .byte_value (byte_value),
    .uptime_ms  (uptime_ms),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .action     (action),
    .green_led  (green_led),
    .red_led    (red_led),
    .up_days    (up_days),
    .up_hours   (up_hours),
    .up_minutes (up_minutes),
    .up_seconds (up_seconds),
    .up_millis  (up_millis)
  );

  always #4 clk = ~clk;

  // session predictor: one beat in, one result out
  function automatic session_result_t step_session(input func_t f, input logic [7:0] c,
                                                   input logic [31:0] up);
    session_result_t r;
    session_mode_t   prev_mode;
    logic            blank;
    int unsigned     t;
    r = '0;
    r.action = ACT_NONE;
    prev_mode = session_mode;
    blank = (c == CH_SP) || (c == CH_TAB) || (c == CH_CR);
    if (f == FUNC_OPEN) begin
      session_mode = PM_INIT;
      idle_count = idle_reload;
      r.action = ACT_GREET;
    end else if (f == FUNC_CLOSE) begin
      session_mode = PM_CLOSED;
    end else if (session_mode != PM_CLOSED) begin
      if (f == FUNC_POLL) begin
        if (idle_count <= 16'd1) begin
          idle_count = 16'd0;
          session_mode = PM_CLOSED;
          r.action = ACT_TIMEOUT;
        end else begin
          idle_count = idle_count - 16'd1;
        end
      end else begin
        idle_count = idle_reload;
        case (prev_mode)
          PM_INIT: begin
            if (c == CH_IAC) begin
              session_mode = PM_IAC;
            end else if (c == CH_LF) begin
              r.action = ACT_PROMPT;
            end else if (!blank) begin
              case (c)
                CMD_HELP, CMD_QUERY: session_mode = PM_HELP;
                CMD_GREEN_ON:        session_mode = PM_GREEN_ON;
                CMD_GREEN_OFF:       session_mode = PM_GREEN_OFF;
                CMD_RED_ON:          session_mode = PM_RED_ON;
                CMD_RED_OFF:         session_mode = PM_RED_OFF;
                CMD_TIME:            session_mode = PM_TIME;
                CMD_EXIT:            session_mode = PM_EXIT;
                default:             session_mode = PM_SWALLOW;
              endcase
            end
          end
          PM_IAC: session_mode = (c >= CH_WILL && c <= CH_DONT) ? PM_OPTION : PM_SWALLOW;
          PM_OPTION: session_mode = PM_INIT;
          PM_SWALLOW: begin
            if (c == CH_LF) begin
              session_mode = PM_INIT;
              r.action = ACT_ERROR;
            end
          end
          default: begin
            // letter seen, waiting for its newline
            if (!blank && c != CH_LF) begin
              session_mode = PM_SWALLOW;
            end else if (c == CH_LF) begin
              session_mode = PM_INIT;
              case (prev_mode)
                PM_HELP:      r.action = ACT_HELP;
                PM_GREEN_ON:  begin green_level = 1'b1; r.action = ACT_PROMPT; end
                PM_GREEN_OFF: begin green_level = 1'b0; r.action = ACT_PROMPT; end
                PM_RED_ON:    begin red_level = 1'b1; r.action = ACT_PROMPT; end
                PM_RED_OFF:   begin red_level = 1'b0; r.action = ACT_PROMPT; end
                PM_TIME:      r.action = ACT_TIME;
                PM_EXIT:      begin session_mode = PM_CLOSED; r.action = ACT_EXIT; end
                default:      r.action = ACT_NONE;
              endcase
            end
          end
        endcase
      end
    end
    // uptime split for the time report
    if (r.action == ACT_TIME) begin
      t = up;
      r.millis = 10'(t % 1000); t = t / 1000;
      r.seconds = 6'(t % 60);   t = t / 60;
      r.minutes = 6'(t % 60);   t = t / 60;
      r.hours = 5'(t % 24);     t = t / 24;
      r.days = 6'(t);
    end
    r.green = green_level;
    r.red = red_level;
    return r;
  endfunction

  function automatic logic [31:0] rand_uptime();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // drive one beat and hold it until taken
  task automatic send_beat(input func_t f, input logic [7:0] c, input logic [31:0] up);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    func = f;
    byte_value = c;
    uptime_ms = up;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(step_session(f, c, up));
    beats_sent++;
  endtask

  task automatic send_byte(input logic [7:0] c);
    send_beat(FUNC_BYTE, c, rand_uptime());
  endtask

  task automatic send_event(input func_t f);
    send_beat(f, 8'($urandom_range(0, 255)), rand_uptime());
  endtask

  // hold off until every expected beat is back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reload(input logic [15:0] value);
    drain_results();
    repeat (8) @(negedge clk);
    cfg_wr_data = value;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    idle_reload = value;
  endtask

  // each command but red off, blanks, option skipping and error paths
  task automatic test_directed_commands();
    send_byte(CMD_TIME);
    send_event(FUNC_POLL);
    send_event(FUNC_OPEN);
    send_byte(CH_LF);
    send_byte(CMD_GREEN_ON);
    send_byte(CH_LF);
    send_byte(CMD_RED_ON);
    send_byte(CH_SP);
    send_byte(CH_TAB);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CMD_HELP);
    send_byte(CH_LF);
    send_byte(CMD_QUERY);
    send_byte(CH_LF);
    send_byte(CMD_TIME);
    send_beat(FUNC_BYTE, CH_LF, 32'hffff_ffff);
    send_byte(CH_IAC);
    send_byte(CH_DO);
    send_byte(8'h18);
    send_byte(CH_IAC);
    send_byte(8'h00);
    send_byte(CH_LF);
    send_byte(CMD_DOLLAR);
    send_byte(CH_LF);
    send_byte(CMD_GREEN_OFF);
    send_byte(CH_IAC);
    send_byte(CH_LF);
    send_byte(CMD_EXIT);
    send_byte(CH_LF);
  endtask

  // zero and unit reload, restart while open, peer close
  task automatic test_idle_timeout();
    write_reload(16'd0);
    send_event(FUNC_OPEN);
    send_byte(CH_SP);
    send_event(FUNC_POLL);
    write_reload(16'd1);
    send_event(FUNC_OPEN);
    send_event(FUNC_OPEN);
    send_event(FUNC_POLL);
    send_event(FUNC_OPEN);
    send_event(FUNC_CLOSE);
    send_event(FUNC_POLL);
  endtask

  // mostly well-formed command lines inside sessions, with noise
  task automatic test_random_sessions(input int send_pct, input int recv_pct,
                                      input logic [15:0] reload, input int beats);
    int          target;
    int          pick;
    logic [7:0]  letter;
    logic [7:0]  blank;
    write_reload(reload);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = beats_sent + beats;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      if (session_mode == PM_CLOSED && pick < 85) begin
        send_event(FUNC_OPEN);
      end else if (pick < 8) begin
        repeat ($urandom_range(1, 4)) send_event(FUNC_POLL);
      end else if (pick < 11) begin
        send_event(FUNC_OPEN);
      end else if (pick < 13) begin
        send_event(FUNC_CLOSE);
      end else if (pick < 20) begin
        send_byte(CH_IAC);
        if ($urandom_range(0, 4) != 0) begin
          send_byte(8'($urandom_range(CH_WILL, CH_DONT)));
        end else begin
          send_byte(8'($urandom_range(0, 255)));
        end
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 27) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 28) begin
        drain_results();
      end else begin
        case ($urandom_range(0, 9))
          0:       letter = CMD_HELP;
          1:       letter = CMD_QUERY;
          2:       letter = CMD_GREEN_ON;
          3:       letter = CMD_GREEN_OFF;
          4:       letter = CMD_RED_ON;
          5:       letter = CMD_RED_OFF;
          6:       letter = CMD_TIME;
          7:       letter = CMD_EXIT;
          8:       letter = CMD_DOLLAR;
          default: letter = 8'($urandom_range(0, 255));
        endcase
        send_byte(letter);
        repeat ($urandom_range(0, 2)) begin
          case ($urandom_range(0, 2))
            0:       blank = CH_SP;
            1:       blank = CH_TAB;
            default: blank = CH_CR;
          endcase
          send_byte(blank);
        end
        if ($urandom_range(0, 9) == 0) send_event(FUNC_POLL);
        if ($urandom_range(0, 9) == 0) begin
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_byte(CH_LF);
        end
      end
    end
  endtask

  // receiver stall
  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < recv_idle_pct);
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // result beat check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected, action %0d", action);
        fail_count++;
      end else begin
        result_want = pending_results.pop_front();
        check_field("action", 32'(result_want.action), 32'(action));
        check_field("green_led", 32'(result_want.green), 32'(green_led));
        check_field("red_led", 32'(result_want.red), 32'(red_led));
        check_field("up_days", 32'(result_want.days), 32'(up_days));
        check_field("up_hours", 32'(result_want.hours), 32'(up_hours));
        check_field("up_minutes", 32'(result_want.minutes), 32'(up_minutes));
        check_field("up_seconds", 32'(result_want.seconds), 32'(up_seconds));
        check_field("up_millis", 32'(result_want.millis), 32'(up_millis));
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 75;
    test_directed_commands();
    test_idle_timeout();
    test_random_sessions(16, 75, 16'd3, BEATS_PER_PHASE);
    test_random_sessions(75, 16, 16'hffff, BEATS_PER_PHASE);
    test_random_sessions(0, 0, 16'($urandom_range(2, 6)), BEATS_PER_PHASE);
    @(negedge clk);
    in_valid = 1'b0;
    end_wait = 0;
    while (pending_results.size() != 0 && end_wait < 2000) begin
      @(posedge clk);
      end_wait++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d result beats never arrived", pending_results.size());
      fail_count++;
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
